FILE: sv/wsfe_pkg.sv
// ----------------------------------------------------------------------------
// wsfe_pkg
// Shared types, constants and helpers for the masked frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfe_pkg;

    // input kind codes carried on tuser
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    // header constants
    localparam logic [7:0]  HDR_FIN_TEXT = 8'h81;   // fin plus text opcode
    localparam logic [7:0]  MASK_BIT     = 8'h80;
    localparam logic [31:0] LEN7_MAX     = 32'd125;
    localparam logic [6:0]  LEN16_MARK   = 7'd126;
    localparam logic [6:0]  LEN64_MARK   = 7'd127;
    localparam logic [31:0] KEY_RESET    = 32'h1234_5678;

    // header byte index where the mask key starts, per length form
    localparam logic [3:0] KEY_BASE_SHORT = 4'd2;
    localparam logic [3:0] KEY_BASE_MID   = 4'd4;
    localparam logic [3:0] KEY_BASE_LONG  = 4'd10;

    // one output byte with its flags
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } byte_item_t;

    // mask byte for a position, most significant key byte first
    function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = key[31:24];
            2'd1:    b = key[23:16];
            2'd2:    b = key[15:8];
            default: b = key[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: sv/websocket_masked_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// websocket_masked_frame_encoder_top
// Masked client frame encoder producing a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes items: tuser 0 opens a frame of the payload length
//   in tdata[31:0], tuser 1 is a payload byte in tdata[39:32]. The m_ channel
//   gives one frame byte per item, tlast on the final frame byte, tuser set
//   when a payload byte arrives with no frame open.
//   cfg_we/cfg_wdata load the 32-bit mask key; write it only while idle.
//   The first byte of an item reaches m_tdata by way of the item holder
//   register and then the output register.
//   A payload item gives one byte; a start item gives 6, 8 or 14 header
//   bytes (7-bit, 16-bit or 64-bit length form), one per cycle while not
//   stalled, set by the header byte sequencer. Items can follow back to back.
//   Reset clears the open frame, the held item and the output register and
//   loads the mask key with 0x12345678.
//   When m_tready is low the output register holds its byte, the held item
//   waits, and s_tready drops once the item holder is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_masked_frame_encoder_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,     // [31:0] mask key bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,       // [31:0] frame_length, [39:32] data_byte
    input  wire logic        s_tuser,       // [0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,       // [7:0] out_byte
    output logic             m_tlast,
    output logic             m_tuser        // [0] error
);

    logic [31:0]          key_word_reg;
    logic                 emit_valid;
    logic                 emit_ready;
    wsfe_pkg::byte_item_t emit;
    wsfe_pkg::byte_item_t out_item;

    // mask key register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_word_reg <= wsfe_pkg::KEY_RESET;
        end else if (cfg_we) begin
            key_word_reg <= cfg_wdata;
        end
    end

    wsfe_frame_ctl u_ctl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_length  (s_tdata[31:0]),
        .in_data    (s_tdata[39:32]),
        .key_word   (key_word_reg),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .emit       (emit)
    );

    wsfe_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (emit_valid),
        .in_ready  (emit_ready),
        .in_item   (emit),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = out_item.out_byte;
    assign m_tlast = out_item.last;
    assign m_tuser = out_item.error;

endmodule

`default_nettype wire

FILE: sv/wsfe_hdr_gen.sv
// ----------------------------------------------------------------------------
// wsfe_hdr_gen
// Selects the header byte at a given index for a frame of a given length.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfe_hdr_gen (
    input  wire logic [31:0] frame_length,
    input  wire logic [3:0]  hdr_idx,
    input  wire logic [31:0] key_word,
    output logic      [7:0]  hdr_byte,
    output logic             hdr_final
);

    logic       is_short;
    logic       is_mid;
    logic [3:0] key_base;
    logic [3:0] key_off;

    // length form and where the key bytes begin
    always_comb begin
        is_short = (frame_length <= wsfe_pkg::LEN7_MAX);
        is_mid   = !is_short && (frame_length[31:16] == 16'd0);
        if (is_short) begin
            key_base = wsfe_pkg::KEY_BASE_SHORT;
        end else if (is_mid) begin
            key_base = wsfe_pkg::KEY_BASE_MID;
        end else begin
            key_base = wsfe_pkg::KEY_BASE_LONG;
        end
        key_off   = hdr_idx - key_base;
        hdr_final = (hdr_idx == key_base + 4'd3);
    end

    // byte selection
    always_comb begin
        if (hdr_idx == 4'd0) begin
            hdr_byte = wsfe_pkg::HDR_FIN_TEXT;
        end else if (hdr_idx == 4'd1) begin
            if (is_short) begin
                hdr_byte = wsfe_pkg::MASK_BIT | {1'b0, frame_length[6:0]};
            end else if (is_mid) begin
                hdr_byte = wsfe_pkg::MASK_BIT | {1'b0, wsfe_pkg::LEN16_MARK};
            end else begin
                hdr_byte = wsfe_pkg::MASK_BIT | {1'b0, wsfe_pkg::LEN64_MARK};
            end
        end else if (hdr_idx >= key_base) begin
            hdr_byte = wsfe_pkg::key_byte(key_word, key_off[1:0]);
        end else if (is_mid) begin
            hdr_byte = (hdr_idx == 4'd2) ? frame_length[15:8] : frame_length[7:0];
        end else begin
            // long form: four zero bytes, then the 32-bit length big-endian
            case (hdr_idx)
                4'd6:    hdr_byte = frame_length[31:24];
                4'd7:    hdr_byte = frame_length[23:16];
                4'd8:    hdr_byte = frame_length[15:8];
                4'd9:    hdr_byte = frame_length[7:0];
                default: hdr_byte = 8'h00;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/wsfe_frame_ctl.sv
// ----------------------------------------------------------------------------
// wsfe_frame_ctl
// Holds one input item, tracks the open frame and emits one byte per cycle while the output stage accepts.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfe_frame_ctl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 in_mode,
    input  wire logic [31:0]          in_length,
    input  wire logic [7:0]           in_data,
    input  wire logic [31:0]          key_word,
    output logic                      emit_valid,
    input  wire logic                 emit_ready,
    output wsfe_pkg::byte_item_t      emit
);

    logic        item_valid_reg;
    logic        item_mode_reg;
    logic [31:0] item_len_reg;
    logic [7:0]  item_data_reg;
    logic [3:0]  hdr_idx_reg;
    logic [3:0]  hdr_idx_next;
    logic [31:0] bytes_left_reg;
    logic [31:0] bytes_left_next;
    logic [1:0]  mask_pos_reg;
    logic [1:0]  mask_pos_next;
    logic        frame_open_reg;
    logic        frame_open_next;

    logic [7:0]  hdr_byte;
    logic        hdr_final;
    logic        fire;
    logic        item_done;

    wsfe_hdr_gen u_hdr (
        .frame_length (item_len_reg),
        .hdr_idx      (hdr_idx_reg),
        .key_word     (key_word),
        .hdr_byte     (hdr_byte),
        .hdr_final    (hdr_final)
    );

    // handshake toward the output stage and the input side
    assign emit_valid = item_valid_reg;
    assign fire       = item_valid_reg && emit_ready;
    assign item_done  = fire && ((item_mode_reg == wsfe_pkg::MODE_DATA) || hdr_final);
    assign in_ready   = !item_valid_reg || item_done;

    // byte and next state for the held item
    always_comb begin
        emit            = '0;
        hdr_idx_next    = hdr_idx_reg;
        bytes_left_next = bytes_left_reg;
        mask_pos_next   = mask_pos_reg;
        frame_open_next = frame_open_reg;
        if (item_mode_reg == wsfe_pkg::MODE_START) begin
            emit.out_byte = hdr_byte;
            emit.last     = hdr_final && (item_len_reg == 32'd0);
            if (fire) begin
                if (hdr_final) begin
                    hdr_idx_next    = 4'd0;
                    bytes_left_next = item_len_reg;
                    mask_pos_next   = 2'd0;
                    frame_open_next = (item_len_reg != 32'd0);
                end else begin
                    hdr_idx_next = hdr_idx_reg + 4'd1;
                end
            end
        end else if (!frame_open_reg) begin
            // payload with no frame open
            emit.error = 1'b1;
        end else begin
            emit.out_byte = item_data_reg ^ wsfe_pkg::key_byte(key_word, mask_pos_reg);
            emit.last     = (bytes_left_reg == 32'd1);
            if (fire) begin
                bytes_left_next = bytes_left_reg - 32'd1;
                mask_pos_next   = mask_pos_reg + 2'd1;
                frame_open_next = (bytes_left_reg != 32'd1);
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            hdr_idx_reg    <= 4'd0;
            bytes_left_reg <= 32'd0;
            mask_pos_reg   <= 2'd0;
            frame_open_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                item_valid_reg <= in_valid;
            end
            hdr_idx_reg    <= hdr_idx_next;
            bytes_left_reg <= bytes_left_next;
            mask_pos_reg   <= mask_pos_next;
            frame_open_reg <= frame_open_next;
        end
    end

    // item payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_mode_reg <= in_mode;
            item_len_reg  <= in_length;
            item_data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/wsfe_out_stage.sv
// ----------------------------------------------------------------------------
// wsfe_out_stage
// Output register that holds one byte item until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfe_out_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire wsfe_pkg::byte_item_t in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output wsfe_pkg::byte_item_t      out_item
);

    logic                 valid_reg;
    wsfe_pkg::byte_item_t item_reg;

    // free when empty or being drained this cycle
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

FILE: sv/wsfe_checker.sv
// ----------------------------------------------------------------------------
// wsfe_checker
// Port-level checks for the masked frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfe_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    // output register empties on reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // item holder is free after reset
    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // an error item never closes a frame
    a_err_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tlast)
        else $error("error item flagged last");

    // an error item carries a zero byte
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 8'h00)
        else $error("error item with nonzero byte");

    // a stalled item holds its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
        && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled item changed");

endmodule

bind websocket_masked_frame_encoder_top wsfe_checker u_wsfe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
